// ===== hdl/ess_pkg.sv =====
// Shared types and constants of the elevator sweep scheduler.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package ess_pkg;

	// Field widths.
	localparam int FLOOR_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;

	// Default size of the request table.
	localparam int REQUEST_SLOTS_DEF = 16;

	// Register reset values and the lowest usable top floor.
	localparam logic [FLOOR_W-1:0] TOP_FLOOR_RST   = 6'd10;
	localparam logic [FLOOR_W-1:0] START_FLOOR_RST = 6'd1;
	localparam logic [FLOOR_W-1:0] MIN_TOP_FLOOR   = 6'd2;
	localparam logic [FLOOR_W-1:0] BOTTOM_FLOOR    = 6'd1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_FLOOR = 1'b1;

	// Item modes.
	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	// Request status codes.
	localparam logic [STATUS_W-1:0] REQ_NONE     = 2'd0;
	localparam logic [STATUS_W-1:0] REQ_ACCEPTED = 2'd1;
	localparam logic [STATUS_W-1:0] REQ_REFUSED  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic req_step;
		logic scan_issue;
		logic move;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_done;
		logic idx_last;
	} sts_t;

endpackage

// ===== hdl/ess_ctrl.sv =====
// Controller state machine of the elevator sweep scheduler.
// Sequences request searches, slot scans, the move step and the output beat.
// Depends on ess_pkg.
module ess_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          mode,
	output logic          out_valid,
	input  logic          out_ready,
	input  ess_pkg::sts_t sts,
	output ess_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REQ,
		S_SCAN,
		S_DRAIN,
		S_MOVE,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands follow the state alone, apart from the handshakes.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.accept     = in_valid;
			S_REQ:   cmd.req_step   = 1'b1;
			S_SCAN:  cmd.scan_issue = 1'b1;
			S_DRAIN: cmd            = '0;
			S_MOVE:  cmd.move       = 1'b1;
			S_FIN:   cmd.load_out   = !out_valid_q || out_ready;
			default: cmd            = '0;
		endcase
	end

	// State register and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (mode == ess_pkg::MODE_TICK) ? S_SCAN : S_REQ;
					end
				end
				S_REQ: begin
					if (sts.req_done) begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (sts.idx_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_MOVE;
				S_MOVE:  state_q <= S_FIN;
				S_FIN: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/ess_datapath.sv =====
// Datapath of the elevator sweep scheduler: registers, request table, counters.
// Carries out the commands of ess_ctrl and reports search progress.
// Depends on ess_pkg.
module ess_datapath #(
	parameter int REQUEST_SLOTS = ess_pkg::REQUEST_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ess_pkg::cmd_t                       cmd,
	output ess_pkg::sts_t                       sts,
	input  logic                                cfg_valid,
	input  logic [ess_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ess_pkg::FLOOR_W-1:0]         cfg_data,
	input  logic                                mode,
	input  logic [ess_pkg::FLOOR_W-1:0]         pickup_floor,
	input  logic [ess_pkg::FLOOR_W-1:0]         drop_floor,
	output logic [ess_pkg::FLOOR_W-1:0]         car_floor,
	output logic                                going_up,
	output logic                                stopped_here,
	output logic [ess_pkg::COUNT_W-1:0]         boarded,
	output logic [ess_pkg::COUNT_W-1:0]         alighted,
	output logic                                idle,
	output logic [ess_pkg::STATUS_W-1:0]        request_status
);

	localparam int IDX_W = $clog2(REQUEST_SLOTS);
	localparam int CNT_W = $clog2(REQUEST_SLOTS + 1);
	localparam int FW    = ess_pkg::FLOOR_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REQUEST_SLOTS - 1);

	typedef enum logic [1:0] {
		SLOT_FREE,
		SLOT_WAIT,
		SLOT_RIDE
	} slot_state_t;

	// Configuration and car state.
	logic [FW-1:0]    top_q;
	logic [FW-1:0]    car_q;
	logic             dir_q;
	logic             running_q;

	// Item registers.
	logic [FW-1:0]    pick_q;
	logic [FW-1:0]    drop_q;
	logic             floors_ok_q;
	logic             start_tick_q;
	logic [ess_pkg::STATUS_W-1:0] req_status_q;

	// Table state, scan index and counters.
	slot_state_t      slot_q [REQUEST_SLOTS];
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] pending_q;
	logic [CNT_W-1:0] nb_q;
	logic [CNT_W-1:0] na_q;

	// Nearest waiting pickup found so far.
	logic             best_vld_q;
	logic [FW-1:0]    best_d_q;
	logic [FW-1:0]    best_p_q;

	// Request table memory and the read stage.
	logic [2*FW-1:0]  mem [REQUEST_SLOTS];
	logic [2*FW-1:0]  rd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;

	// Output registers.
	logic [FW-1:0]    car_floor_q;
	logic             going_up_q;
	logic             stopped_q;
	logic [ess_pkg::COUNT_W-1:0] boarded_q;
	logic [ess_pkg::COUNT_W-1:0] alighted_q;
	logic             idle_q;
	logic [ess_pkg::STATUS_W-1:0] status_q;

	logic [FW-1:0]    top_eff;
	logic [FW-1:0]    car_clamp;
	logic             in_floors_ok;
	logic             slot_free_at_idx;
	logic             mem_we;
	logic [FW-1:0]    rd_pick;
	logic [FW-1:0]    rd_drop;
	slot_state_t      st_s1;
	logic [FW-1:0]    pick_dist;
	logic             dir_eff;
	logic             pend_nz;

	// Effective top floor and the car clamped into the served range.
	always_comb begin
		top_eff   = (top_q < ess_pkg::MIN_TOP_FLOOR) ? ess_pkg::MIN_TOP_FLOOR : top_q;
		car_clamp = car_q;
		if (car_q > top_eff) begin
			car_clamp = top_eff;
		end else if (car_q < ess_pkg::BOTTOM_FLOOR) begin
			car_clamp = ess_pkg::BOTTOM_FLOOR;
		end
		in_floors_ok = (pickup_floor >= ess_pkg::BOTTOM_FLOOR) && (pickup_floor <= top_eff)
			&& (drop_floor >= ess_pkg::BOTTOM_FLOOR) && (drop_floor <= top_eff);
	end

	// Request search: the lowest free slot takes the request.
	assign slot_free_at_idx = (slot_q[idx_q] == SLOT_FREE);
	assign mem_we           = cmd.req_step && floors_ok_q && slot_free_at_idx;
	assign sts.idx_last     = (idx_q == LAST_IDX);
	assign sts.req_done     = !floors_ok_q || slot_free_at_idx || sts.idx_last;

	// Scan stage values of the slot read in the previous cycle.
	assign rd_pick   = rd_s1[2*FW-1:FW];
	assign rd_drop   = rd_s1[FW-1:0];
	assign st_s1     = slot_q[idx_s1];
	assign pick_dist = (rd_pick > car_q) ? (rd_pick - car_q) : (car_q - rd_pick);

	// Direction for the move, after a possible start toward the nearest pickup.
	assign dir_eff = (start_tick_q && best_vld_q) ? (best_p_q > car_q) : dir_q;
	assign pend_nz = (pending_q != '0);

	// Request table memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= {pick_q, drop_q};
		end
		rd_s1  <= mem[idx_q];
		idx_s1 <= idx_q;
	end

	// Item, payload and output registers that need no reset.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pick_q      <= pickup_floor;
			drop_q      <= drop_floor;
			floors_ok_q <= in_floors_ok;
		end
		if (cmd.load_out) begin
			car_floor_q <= car_q;
			going_up_q  <= dir_q;
			stopped_q   <= (nb_q != '0) || (na_q != '0);
			boarded_q   <= ess_pkg::COUNT_W'(nb_q);
			alighted_q  <= ess_pkg::COUNT_W'(na_q);
			idle_q      <= !running_q && !pend_nz;
			status_q    <= req_status_q;
		end
	end

	// Control state of the car and the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= ess_pkg::TOP_FLOOR_RST;
			car_q        <= ess_pkg::START_FLOOR_RST;
			dir_q        <= 1'b1;
			running_q    <= 1'b0;
			start_tick_q <= 1'b0;
			req_status_q <= ess_pkg::REQ_NONE;
			idx_q        <= '0;
			vld_s1       <= 1'b0;
			pending_q    <= '0;
			nb_q         <= '0;
			na_q         <= '0;
			best_vld_q   <= 1'b0;
			best_d_q     <= '0;
			best_p_q     <= '0;
			for (int i = 0; i < REQUEST_SLOTS; i++) begin
				slot_q[i] <= SLOT_FREE;
			end
		end else begin
			vld_s1 <= cmd.scan_issue;

			// Configuration beats.
			if (cfg_valid) begin
				if (cfg_index == ess_pkg::CFG_TOP_FLOOR) begin
					top_q <= cfg_data;
				end else if (cfg_index == ess_pkg::CFG_START_FLOOR) begin
					car_q <= cfg_data;
				end
			end

			// New item: clamp the car, clear counters, decide whether the car starts.
			if (cmd.accept) begin
				car_q      <= car_clamp;
				idx_q      <= '0;
				nb_q       <= '0;
				na_q       <= '0;
				best_vld_q <= 1'b0;
				if (mode == ess_pkg::MODE_TICK) begin
					req_status_q <= ess_pkg::REQ_NONE;
					start_tick_q <= !running_q && pend_nz;
					running_q    <= running_q || pend_nz;
				end else begin
					req_status_q <= ess_pkg::REQ_REFUSED;
					start_tick_q <= 1'b0;
				end
			end

			// One step of the free-slot search.
			if (cmd.req_step) begin
				if (mem_we) begin
					slot_q[idx_q] <= SLOT_WAIT;
					pending_q     <= pending_q + CNT_W'(1);
					req_status_q  <= ess_pkg::REQ_ACCEPTED;
				end else if (!sts.req_done) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end

			// Slot scan: issue the next read.
			if (cmd.scan_issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end

			// Slot scan: nearest pickup, boarding and alighting for one slot.
			if (vld_s1) begin
				if (start_tick_q && st_s1 == SLOT_WAIT) begin
					if (!best_vld_q || pick_dist < best_d_q) begin
						best_vld_q <= 1'b1;
						best_d_q   <= pick_dist;
						best_p_q   <= rd_pick;
					end
				end
				if (running_q) begin
					if (st_s1 == SLOT_WAIT && rd_pick == car_q) begin
						nb_q <= nb_q + CNT_W'(1);
						if (rd_drop == car_q) begin
							slot_q[idx_s1] <= SLOT_FREE;
							na_q           <= na_q + CNT_W'(1);
							pending_q      <= pending_q - CNT_W'(1);
						end else begin
							slot_q[idx_s1] <= SLOT_RIDE;
						end
					end else if (st_s1 == SLOT_RIDE && rd_drop == car_q) begin
						slot_q[idx_s1] <= SLOT_FREE;
						na_q           <= na_q + CNT_W'(1);
						pending_q      <= pending_q - CNT_W'(1);
					end
				end
			end

			// Move one floor, reversing at an end while work remains.
			if (cmd.move && running_q) begin
				dir_q <= dir_eff;
				if (dir_eff) begin
					if (car_q < top_eff) begin
						car_q <= car_q + FW'(1);
					end else if (pend_nz) begin
						dir_q <= 1'b0;
						car_q <= car_q - FW'(1);
					end else begin
						running_q <= 1'b0;
					end
				end else begin
					if (car_q > ess_pkg::BOTTOM_FLOOR) begin
						car_q <= car_q - FW'(1);
					end else if (pend_nz) begin
						dir_q <= 1'b1;
						car_q <= car_q + FW'(1);
					end else begin
						running_q <= 1'b0;
					end
				end
			end
		end
	end

	assign car_floor      = car_floor_q;
	assign going_up       = going_up_q;
	assign stopped_here   = stopped_q;
	assign boarded        = boarded_q;
	assign alighted       = alighted_q;
	assign idle           = idle_q;
	assign request_status = status_q;

endmodule

// ===== hdl/elevator_sweep_scheduler_core.sv =====
// Top level of the elevator sweep scheduler.
// Joins the controller ess_ctrl and the datapath ess_datapath; depends on ess_pkg.
//
// A SCAN sweep car controller with a table of REQUEST_SLOTS ride requests. A request
// beat (mode 0) stores a pickup and drop floor in the lowest free slot, or reports
// the table full or a floor out of range; its free-slot search checks one slot per
// cycle. A tick beat (mode 1) scans every slot once through the single read port of
// the request memory, one slot per cycle, to find the nearest waiting pickup and to
// board and unload riders, then moves the car one floor while it runs. One item is
// worked on at a time, and the next item is taken while the previous result still
// waits in the output register. The slot states reset at once; no clearing pass is
// needed. Configuration beats are taken in any cycle and are meant for an idle block;
// writing start_floor also places the car there.
module elevator_sweep_scheduler_core #(
	parameter int REQUEST_SLOTS = ess_pkg::REQUEST_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ess_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ess_pkg::FLOOR_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [ess_pkg::FLOOR_W-1:0]     pickup_floor,
	input  logic [ess_pkg::FLOOR_W-1:0]     drop_floor,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ess_pkg::FLOOR_W-1:0]     car_floor,
	output logic                            going_up,
	output logic                            stopped_here,
	output logic [ess_pkg::COUNT_W-1:0]     boarded,
	output logic [ess_pkg::COUNT_W-1:0]     alighted,
	output logic                            idle,
	output logic [ess_pkg::STATUS_W-1:0]    request_status
);

	ess_pkg::cmd_t cmd;
	ess_pkg::sts_t sts;

	// Configuration writes are always accepted.
	assign cfg_ready = 1'b1;

	ess_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ess_datapath #(
		.REQUEST_SLOTS (REQUEST_SLOTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.pickup_floor   (pickup_floor),
		.drop_floor     (drop_floor),
		.car_floor      (car_floor),
		.going_up       (going_up),
		.stopped_here   (stopped_here),
		.boarded        (boarded),
		.alighted       (alighted),
		.idle           (idle),
		.request_status (request_status)
	);

endmodule

// ===== hdl/ess_checker.sv =====
// Port-level assertions for the elevator sweep scheduler, bound to its top level.
// Depends on ess_pkg and elevator_sweep_scheduler_core.
module ess_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ess_pkg::FLOOR_W-1:0]     car_floor,
	input logic                            going_up,
	input logic                            stopped_here,
	input logic [ess_pkg::COUNT_W-1:0]     boarded,
	input logic [ess_pkg::COUNT_W-1:0]     alighted,
	input logic                            idle,
	input logic [ess_pkg::STATUS_W-1:0]    request_status
);

	// A stalled result beat keeps its payload; stopped_here is not checked here.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(car_floor) && $stable(going_up)
			&& $stable(boarded) && $stable(alighted) && $stable(idle)
			&& $stable(request_status))
		else $error("result beat changed while stalled");

	// The stop flag agrees with the boarding and alighting counts.
	a_stop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stopped_here == (boarded != '0 || alighted != '0))
		else $error("stopped_here disagrees with the counts");

	// A request beat never moves passengers.
	a_request_no_riders: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_status != ess_pkg::REQ_NONE |->
			boarded == '0 && alighted == '0 && !stopped_here)
		else $error("passengers moved on a request beat");

	// The car is never reported at floor zero.
	a_car_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> car_floor != '0)
		else $error("car reported at floor zero");

endmodule

bind elevator_sweep_scheduler_core ess_checker u_ess_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.car_floor      (car_floor),
	.going_up       (going_up),
	.stopped_here   (stopped_here),
	.boarded        (boarded),
	.alighted       (alighted),
	.idle           (idle),
	.request_status (request_status)
);
